// ===== design/chmmc_pkg.sv =====
package chmmc_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ACC_FRAC        = 20;
  localparam int TAB_LEN         = 24;
  localparam int DIV_STEPS       = 32;
  localparam int CNT_W           = $clog2(DIV_STEPS);
  localparam int XY_W            = 36;
  localparam int Z_W             = 30;
  localparam int ROUND_SH        = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int ANGLE_LIM       = 180 * (1 << ANGLE_FRAC_BITS);
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(94371840);

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_SEED   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_CAL_MODE = 3'd0,
    REG_MIN_X    = 3'd1,
    REG_MAX_X    = 3'd2,
    REG_MIN_Y    = 3'd3,
    REG_MAX_Y    = 3'd4,
    REG_MIN_Z    = 3'd5,
    REG_MAX_Z    = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_HEAD  = 2'd0,
    SEL_ROLL  = 2'd1,
    SEL_PITCH = 2'd2,
    SEL_NONE  = 2'd3
  } sel_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic               range_error;
    logic signed [15:0] low_x;
    logic signed [15:0] high_x;
    logic signed [15:0] low_y;
    logic signed [15:0] high_y;
    logic signed [15:0] low_z;
    logic signed [15:0] high_z;
  } out_item_t;

  typedef struct packed {
    logic             capture;
    logic             div_init;
    logic             div_step;
    logic             cord_init;
    logic             cord_step;
    logic             cord_save;
    logic             commit;
    sel_t             sel;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
  } stat_t;

  // arctangent of 2^-i in degrees times 2^20
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = Z_W'(47185920);
      5'd1:  v = Z_W'(27855475);
      5'd2:  v = Z_W'(14718068);
      5'd3:  v = Z_W'(7471121);
      5'd4:  v = Z_W'(3750058);
      5'd5:  v = Z_W'(1876857);
      5'd6:  v = Z_W'(938658);
      5'd7:  v = Z_W'(469357);
      5'd8:  v = Z_W'(234682);
      5'd9:  v = Z_W'(117342);
      5'd10: v = Z_W'(58671);
      5'd11: v = Z_W'(29335);
      5'd12: v = Z_W'(14668);
      5'd13: v = Z_W'(7334);
      5'd14: v = Z_W'(3667);
      5'd15: v = Z_W'(1833);
      5'd16: v = Z_W'(917);
      5'd17: v = Z_W'(458);
      5'd18: v = Z_W'(229);
      5'd19: v = Z_W'(115);
      5'd20: v = Z_W'(57);
      5'd21: v = Z_W'(29);
      5'd22: v = Z_W'(14);
      5'd23: v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/compass_heading_min_max_calibration_top.sv =====
// compass heading with min/max hard-iron calibration
// input channel: in_valid/in_stall carry one request transaction (sample,
//   load limits from config, seed limits from sample)
// result channel: out_valid/out_stall carry exactly one result per request
// config port: cfg_we/cfg_idx/cfg_data write cal_mode and the six saved
//   limits, only while the block is idle (a user rule, not enforced)
// a sample or seed runs, from the accepting edge: one prep, the radix-2
//   divider (x and y lanes in parallel), then three passes of one shared
//   cordic unit (init, 16 iterations, save each), and one commit step,
//   held while an earlier result is still stalled, that raises out_valid
// load and idle requests go through prep and commit only
// one request at a time: the next is taken the cycle after the
//   result is written to the output register
// a finished result waits in the output register while the next request
//   is already being worked; a second result waits in the commit state
//   until the first is taken
// reset (rst_n low, synchronous) clears limits, saved registers, cal_mode
//   and all handshake state
module compass_heading_min_max_calibration_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  chmmc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output chmmc_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [15:0]          cfg_data
);
  import chmmc_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  chmmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chmmc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== design/chmmc_ctrl.sv =====
module chmmc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  chmmc_pkg::stat_t stat,
  output chmmc_pkg::cmd_t  cmd
);
  import chmmc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_CINIT = 7'b0001000,
    ST_CSTEP = 7'b0010000,
    ST_CSAVE = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sel_t             sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.idx       = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.req == REQ_SAMPLE || stat.req == REQ_SEED) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          sel_nxt   = SEL_HEAD;
          state_nxt = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.cord_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.cord_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_CSAVE;
      end
      ST_CSAVE: begin
        cmd.cord_save = 1'b1;
        case (sel_r)
          SEL_HEAD: begin
            sel_nxt   = SEL_ROLL;
            state_nxt = ST_CINIT;
          end
          SEL_ROLL: begin
            sel_nxt   = SEL_PITCH;
            state_nxt = ST_CINIT;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= SEL_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_PREP) else $error("accepted input did not start work");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r) else $error("commit did not raise out_valid");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN)) else $error("result outside finish");

endmodule

// ===== design/chmmc_dp.sv =====
module chmmc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  chmmc_pkg::in_item_t in_data,
  input  chmmc_pkg::cmd_t     cmd,
  output chmmc_pkg::stat_t    stat,
  output chmmc_pkg::out_item_t out_data
);
  import chmmc_pkg::*;

  in_item_t           in_r;
  logic               cal_mode_r;
  logic signed [15:0] saved_r [6];
  logic signed [15:0] lo_r [3];
  logic signed [15:0] hi_r [3];
  logic signed [15:0] lo_nxt [3];
  logic signed [15:0] hi_nxt [3];
  logic signed [15:0] mag [3];

  // divider lanes for x and y
  logic [17:0] remx_r, remy_r;
  logic [31:0] quox_r, quoy_r;
  logic [16:0] denx_r, deny_r;
  logic        negx_r, negy_r;

  logic signed [XY_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]  cz_r;
  logic                   czero_r;
  logic signed [15:0]     head_r, roll_r, pitch_r;
  out_item_t              out_r;

  logic                   range_err;
  logic signed [XY_W-1:0] xi, yi, qx_s, qy_s;
  logic signed [Z_W-1:0]  zr, zsh;
  logic signed [15:0]     ang;
  logic                   is_samp;

  assign stat.req = in_r.req_type;
  assign out_data = out_r;
  assign mag[0]   = in_r.mag_x;
  assign mag[1]   = in_r.mag_y;
  assign mag[2]   = in_r.mag_z;
  assign is_samp  = (in_r.req_type == REQ_SAMPLE) || (in_r.req_type == REQ_SEED);
  assign range_err = (hi_r[0] == lo_r[0]) || (hi_r[1] == lo_r[1]);

  function automatic logic [49:0] div_it(input logic [17:0] rem, input logic [31:0] quo,
                                         input logic [16:0] den);
    logic [17:0] rs;
    logic [31:0] qs;
    rs = {rem[16:0], quo[31]};
    qs = {quo[30:0], 1'b0};
    if (rs >= {1'b0, den}) begin
      rs    = rs - {1'b0, den};
      qs[0] = 1'b1;
    end
    return {rs, qs};
  endfunction

  // twice the centred reading times 2^14 and the limit range, as magnitudes and sign
  function automatic logic [49:0] div_prep(input logic signed [15:0] m,
                                           input logic signed [15:0] lo,
                                           input logic signed [15:0] hi);
    logic signed [17:0] n;
    logic signed [31:0] num;
    logic signed [16:0] r;
    logic [31:0]        nm;
    logic [16:0]        rm;
    n   = {m[15], m, 1'b0} - (18'(hi) + 18'(lo));
    num = {n[17:0], 14'b0};
    r   = 17'(hi) - 17'(lo);
    nm  = num[31] ? 32'(-num) : 32'(num);
    rm  = r[16] ? 17'(-r) : 17'(r);
    return {num[31] ^ r[16], nm, rm};
  endfunction

  always_comb begin
    qx_s = negx_r ? -XY_W'({1'b0, quox_r}) : XY_W'({1'b0, quox_r});
    qy_s = negy_r ? -XY_W'({1'b0, quoy_r}) : XY_W'({1'b0, quoy_r});
    case (cmd.sel)
      SEL_HEAD: begin
        xi = qx_s;
        yi = qy_s;
      end
      SEL_ROLL: begin
        xi = {{(XY_W-30){in_r.accel_z[15]}}, in_r.accel_z, 14'b0};
        yi = {{(XY_W-30){in_r.accel_x[15]}}, in_r.accel_x, 14'b0};
      end
      default: begin
        xi = {{(XY_W-30){in_r.accel_z[15]}}, in_r.accel_z, 14'b0};
        yi = {{(XY_W-30){in_r.accel_y[15]}}, in_r.accel_y, 14'b0};
      end
    endcase
    zr  = cz_r + Z_W'(1 << (ROUND_SH - 1));
    zsh = zr >>> ROUND_SH;
    if (czero_r)                        ang = '0;
    else if (zsh > Z_W'(ANGLE_LIM))     ang = 16'(ANGLE_LIM);
    else if (zsh < -Z_W'(ANGLE_LIM))    ang = -16'(ANGLE_LIM);
    else                                ang = zsh[15:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_nxt[i] = lo_r[i];
      hi_nxt[i] = hi_r[i];
      if (is_samp && cal_mode_r) begin
        if (lo_r[i] > mag[i]) lo_nxt[i] = mag[i];
        if (hi_r[i] < mag[i]) hi_nxt[i] = mag[i];
      end
      if (in_r.req_type == REQ_SEED) begin
        lo_nxt[i] = mag[i];
        hi_nxt[i] = mag[i];
      end
      if (in_r.req_type == REQ_LOAD) begin
        lo_nxt[i] = saved_r[2*i];
        hi_nxt[i] = saved_r[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_mode_r <= 1'b0;
      for (int i = 0; i < 6; i++) saved_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_CAL_MODE: cal_mode_r <= cfg_data[0];
          REG_MIN_X:    saved_r[0] <= cfg_data;
          REG_MAX_X:    saved_r[1] <= cfg_data;
          REG_MIN_Y:    saved_r[2] <= cfg_data;
          REG_MAX_Y:    saved_r[3] <= cfg_data;
          REG_MIN_Z:    saved_r[4] <= cfg_data;
          REG_MAX_Z:    saved_r[5] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        for (int i = 0; i < 3; i++) begin
          lo_r[i] <= lo_nxt[i];
          hi_r[i] <= hi_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.div_init) begin
      {negx_r, quox_r, denx_r} <= div_prep(in_r.mag_x, lo_r[0], hi_r[0]);
      {negy_r, quoy_r, deny_r} <= div_prep(in_r.mag_y, lo_r[1], hi_r[1]);
      remx_r <= '0;
      remy_r <= '0;
    end
    if (cmd.div_step) begin
      {remx_r, quox_r} <= div_it(remx_r, quox_r, denx_r);
      {remy_r, quoy_r} <= div_it(remy_r, quoy_r, deny_r);
    end
    if (cmd.cord_init) begin
      czero_r <= (xi == '0) && (yi == '0);
      if (xi < 0) begin
        if (yi >= 0) begin
          cx_r <= yi;
          cy_r <= -xi;
          cz_r <= QUARTER_TURN;
        end else begin
          cx_r <= -yi;
          cy_r <= xi;
          cz_r <= -QUARTER_TURN;
        end
      end else begin
        cx_r <= xi;
        cy_r <= yi;
        cz_r <= '0;
      end
    end
    if (cmd.cord_step) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + (cy_r >>> cmd.idx);
        cy_r <= cy_r - (cx_r >>> cmd.idx);
        cz_r <= cz_r + atan_tab(cmd.idx);
      end else begin
        cx_r <= cx_r - (cy_r >>> cmd.idx);
        cy_r <= cy_r + (cx_r >>> cmd.idx);
        cz_r <= cz_r - atan_tab(cmd.idx);
      end
    end
    if (cmd.cord_save) begin
      case (cmd.sel)
        SEL_HEAD: head_r  <= ang;
        SEL_ROLL: roll_r  <= ang;
        default:  pitch_r <= ang;
      endcase
    end
    if (cmd.commit) begin
      out_r.heading     <= (is_samp && !range_err) ? head_r : '0;
      out_r.roll_angle  <= is_samp ? roll_r : '0;
      out_r.pitch_angle <= is_samp ? pitch_r : '0;
      out_r.range_error <= is_samp && range_err;
      out_r.low_x       <= lo_nxt[0];
      out_r.high_x      <= hi_nxt[0];
      out_r.low_y       <= lo_nxt[1];
      out_r.high_y      <= hi_nxt[1];
      out_r.low_z       <= lo_nxt[2];
      out_r.high_z      <= hi_nxt[2];
    end
  end

endmodule
